// ===== rtl/filtered_derivative_step_top_assert.svh =====
// assertion macros for the filtered derivative block
`ifndef FILTERED_DERIVATIVE_STEP_TOP_ASSERT_SVH
`define FILTERED_DERIVATIVE_STEP_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define FDS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("fds assertion failed");
`define FDS_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("fds forbidden condition");
`else
`define FDS_ASSERT(name, prop)
`define FDS_ASSERT_NEVER(name, expr)
`endif
`endif

// ===== rtl/fds_pkg.sv =====
// shared constants and saturation helpers for the filtered derivative block
package fds_pkg;

  localparam int unsigned ValueW        = 32;
  localparam int unsigned MaxSubstepsDef = 100;
  localparam int unsigned ProdW         = 70;

  // configuration register indexes
  localparam logic [1:0] RegGain   = 2'd0;
  localparam logic [1:0] RegOffset = 2'd1;
  localparam logic [1:0] RegTc     = 2'd2;

  localparam logic signed [31:0] GainReset = 32'sd65536;
  localparam logic [23:0]        TcReset   = 24'd20;

  // ceil(2^34 / 5)
  localparam logic [31:0] Recip5 = 32'hCCCC_CCCD;

  function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] x);
    if (x > 70'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (x < -70'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return x[31:0];
  endfunction

  function automatic logic signed [32:0] sat33(input logic signed [ProdW-1:0] x);
    if (x > 70'sd4294967295) begin
      return {1'b0, {32{1'b1}}};
    end else if (x < -70'sd4294967296) begin
      return {1'b1, {32{1'b0}}};
    end
    return x[32:0];
  endfunction

  function automatic logic signed [35:0] sat36(input logic signed [ProdW-1:0] x);
    if (x > 70'sd34359738367) begin
      return {1'b0, {35{1'b1}}};
    end else if (x < -70'sd34359738368) begin
      return {1'b1, {35{1'b0}}};
    end
    return x[35:0];
  endfunction

endpackage

// ===== rtl/filtered_derivative_step_top.sv =====
// paths: snap path with no divide, single trapezoid step with two divides, and
// sub-step path with four divides around n sub-steps (capped at MAX_SUBSTEPS)
// one sample at a time: a new sample is taken only once the result is passed on; each
// divide holds the shared radix-2 divider, each sub-step uses the shared 34x36 multiplier
// reset: asynchronous active low; gain 1.0, offset 0, time constant 20,
// lag, last time and last sample cleared, no result pending
`include "filtered_derivative_step_top_assert.svh"
module filtered_derivative_step_top #(
  parameter int unsigned MAX_SUBSTEPS = fds_pkg::MaxSubstepsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [31:0]        sample_time_i,
  input  logic signed [31:0] sample_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] derivative_out_o
);

  localparam int unsigned NW = $clog2(MAX_SUBSTEPS + 1);

  typedef enum logic [24:0] {
    ST_IDLE    = 25'h000_0001,
    ST_DECIDE  = 25'h000_0002,
    ST_SNAP    = 25'h000_0004,
    ST_SNAP_W  = 25'h000_0008,
    ST_SG_AVG  = 25'h000_0010,
    ST_SG_W    = 25'h000_0020,
    ST_SG_UPD  = 25'h000_0040,
    ST_SG_LAG  = 25'h000_0080,
    ST_SS_N    = 25'h000_0100,
    ST_SS_Q    = 25'h000_0200,
    ST_SS_NT   = 25'h000_0400,
    ST_SS_INIT = 25'h000_0800,
    ST_K_INK   = 25'h000_1000,
    ST_K_INKW  = 25'h000_2000,
    ST_K_AVG   = 25'h000_4000,
    ST_K_Y     = 25'h000_8000,
    ST_K_YM    = 25'h001_0000,
    ST_K_UPD   = 25'h002_0000,
    ST_FN_AVG  = 25'h004_0000,
    ST_FN_D    = 25'h008_0000,
    ST_FN_W    = 25'h010_0000,
    ST_FN_M    = 25'h020_0000,
    ST_FN_LAG  = 25'h040_0000,
    ST_RATE    = 25'h080_0000,
    ST_OUT     = 25'h100_0000
  } st_e;

  st_e state_q, state_d;

  // configuration and architectural state
  logic signed [31:0] gain_q, off_q, lag_q, ls_q;
  logic [23:0]        tc_q;
  logic [31:0]        last_time_q;

  // per-item work registers
  logic signed [31:0] u_q, avg_q, pin_q, ink_q, ival_q, rate_q;
  logic signed [32:0] diff_q, d_q;
  logic signed [30:0] y_q;
  logic [31:0]        dt_q, f_q, q0_q;
  logic [23:0]        t1_q;
  logic [36:0]        dt20_q, r_q, r0_q;
  logic [32:0]        nt1_q;
  logic [34:0]        w_q;
  logic [NW-1:0]      n_q, k_q;

  logic               out_valid_q;
  logic signed [31:0] deriv_q;

  // shared multiplier
  logic signed [33:0]             mul_a;
  logic signed [35:0]             mul_b;
  logic signed [fds_pkg::ProdW-1:0] prod_q;

  // shared divider
  logic [63:0] div_dvd, div_quo_q;
  logic [36:0] div_dvs, div_dvs_q, div_rem_q;
  logic [5:0]  div_cnt_q;
  logic        div_run_q, div_done_q, div_state, div_load;
  logic [37:0] div_trial;
  logic        div_ge;

  logic               in_acc;
  logic signed [32:0] u_sum;
  logic [23:0]        t1_c;
  logic [26:0]        five_t1;
  logic [36:0]        dt20_c;
  logic signed [33:0] d_ext, d_abs;
  logic [36:0]        res_c;
  logic signed [35:0] q5, r5, qc, rq_s;
  logic [37:0]        r_sum;
  logic signed [31:0] lag_new;
  logic signed [32:0] d_sg;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign derivative_out_o = deriv_q;

  assign u_sum   = 33'(sample_value_i) + 33'(off_q);
  assign t1_c    = (tc_q == 24'd0) ? 24'd1 : tc_q;
  assign five_t1 = 27'(t1_q) * 27'd5;
  assign dt20_c  = 37'(dt_q) * 37'd20;
  assign d_ext   = 34'(d_q);
  assign d_abs   = d_ext[33] ? -d_ext : d_ext;
  assign res_c   = dt20_q - 37'(nt1_q);

  // divide by 20 as floor(floor(x/4)/5), reciprocal estimate plus one fix-up
  assign q5 = 36'(prod_q >>> 34);
  assign r5 = 36'(y_q) - q5 * 36'sd5;
  assign qc = (r5 >= 36'sd5) ? q5 + 36'sd1 : q5;
  assign r_sum = 38'(r_q) + 38'(r0_q);

  assign lag_new = fds_pkg::sat32(70'(lag_q) + 70'(fds_pkg::sat33(prod_q >>> 32)));
  assign d_sg    = 33'(avg_q) - 33'(lag_new);

  always_comb begin
    rq_s = 36'($signed({1'b0, div_quo_q[34:0]}));
    if (d_q[32]) begin
      rq_s = -rq_s - ((div_rem_q != 37'd0) ? 36'sd1 : 36'sd0);
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SNAP: begin
        mul_a = 34'(gain_q);
        mul_b = 36'(u_q);
      end
      ST_SG_AVG: begin
        mul_a = 34'(gain_q);
        mul_b = 36'(33'(u_q) + 33'(ls_q));
      end
      ST_SG_UPD: begin
        mul_a = 34'(33'(avg_q) - 33'(lag_q));
        mul_b = $signed({1'b0, w_q});
      end
      ST_SS_NT: begin
        mul_a = $signed(34'(n_q));
        mul_b = $signed(36'(t1_q));
      end
      ST_K_INK: begin
        mul_a = 34'(diff_q);
        mul_b = $signed({4'b0, f_q});
      end
      ST_K_AVG: begin
        mul_a = 34'(gain_q);
        mul_b = 36'(33'(pin_q) + 33'(ink_q));
      end
      ST_K_YM: begin
        mul_a = 34'(y_q);
        mul_b = $signed({4'b0, fds_pkg::Recip5});
      end
      ST_FN_AVG: begin
        mul_a = 34'(gain_q);
        mul_b = 36'(33'(pin_q) + 33'(u_q));
      end
      ST_FN_M: begin
        mul_a = 34'(d_q);
        mul_b = $signed({1'b0, w_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // divider operand select
  always_comb begin
    div_dvd = '0;
    div_dvs = 37'd1;
    unique case (state_q)
      ST_SG_W: begin
        div_dvd = {dt_q, 32'b0};
        div_dvs = 37'(t1_q);
      end
      ST_SS_N: begin
        div_dvd = 64'(dt20_q - 37'd1);
        div_dvs = 37'(t1_q);
      end
      ST_SS_Q: begin
        div_dvd = {8'b0, t1_q, 32'b0};
        div_dvs = dt20_q;
      end
      ST_FN_W: begin
        div_dvd = {res_c[31:0], 32'b0};
        div_dvs = 37'(t1_q) * 37'd20;
      end
      ST_RATE: begin
        div_dvd = 64'(d_abs);
        div_dvs = 37'(t1_q);
      end
      default: begin
        div_dvd = '0;
        div_dvs = 37'd1;
      end
    endcase
  end

  assign div_state = (state_q == ST_SG_W) || (state_q == ST_SS_N) || (state_q == ST_SS_Q) ||
                     (state_q == ST_FN_W) || (state_q == ST_RATE);
  assign div_load  = div_state && !div_run_q && !div_done_q;
  assign div_trial = {div_rem_q, div_quo_q[63]};
  assign div_ge    = div_trial >= {1'b0, div_dvs_q};

  // radix-2 restoring divider, one quotient bit a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_run_q  <= 1'b0;
      div_done_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (div_load) begin
      div_run_q  <= 1'b1;
      div_cnt_q  <= '0;
      div_rem_q  <= '0;
      div_quo_q  <= div_dvd;
      div_dvs_q  <= div_dvs;
    end else if (div_run_q) begin
      div_rem_q <= div_ge ? 37'(div_trial - {1'b0, div_dvs_q}) : div_trial[36:0];
      div_quo_q <= {div_quo_q[62:0], div_ge};
      div_cnt_q <= div_cnt_q + 6'd1;
      if (div_cnt_q == 6'd63) begin
        div_run_q  <= 1'b0;
        div_done_q <= 1'b1;
      end
    end else if (div_state && div_done_q) begin
      div_done_q <= 1'b0;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (in_acc) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (dt_q >= 32'(five_t1)) begin
          state_d = ST_SNAP;
        end else if (dt20_c <= 37'(t1_q)) begin
          state_d = ST_SG_AVG;
        end else begin
          state_d = ST_SS_N;
        end
      end
      ST_SNAP:    state_d = ST_SNAP_W;
      ST_SNAP_W:  state_d = ST_OUT;
      ST_SG_AVG:  state_d = ST_SG_W;
      ST_SG_W:    if (div_done_q) state_d = ST_SG_UPD;
      ST_SG_UPD:  state_d = ST_SG_LAG;
      ST_SG_LAG:  state_d = ST_RATE;
      ST_SS_N:    if (div_done_q) state_d = ST_SS_Q;
      ST_SS_Q:    if (div_done_q) state_d = ST_SS_NT;
      ST_SS_NT:   state_d = ST_SS_INIT;
      ST_SS_INIT: state_d = (n_q == '0) ? ST_FN_AVG : ST_K_INK;
      ST_K_INK:   state_d = ST_K_INKW;
      ST_K_INKW:  state_d = ST_K_AVG;
      ST_K_AVG:   state_d = ST_K_Y;
      ST_K_Y:     state_d = ST_K_YM;
      ST_K_YM:    state_d = ST_K_UPD;
      ST_K_UPD:   state_d = (k_q == n_q) ? ST_FN_AVG : ST_K_INK;
      ST_FN_AVG:  state_d = ST_FN_D;
      ST_FN_D:    state_d = ST_FN_W;
      ST_FN_W:    if (div_done_q) state_d = ST_FN_M;
      ST_FN_M:    state_d = ST_FN_LAG;
      ST_FN_LAG:  state_d = ST_RATE;
      ST_RATE:    if (div_done_q) state_d = ST_OUT;
      ST_OUT:     if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_q      <= fds_pkg::GainReset;
      off_q       <= '0;
      tc_q        <= fds_pkg::TcReset;
      lag_q       <= '0;
      ls_q        <= '0;
      last_time_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fds_pkg::RegGain:   gain_q <= $signed(cfg_data_i);
          fds_pkg::RegOffset: off_q  <= $signed(cfg_data_i);
          fds_pkg::RegTc:     tc_q   <= cfg_data_i[23:0];
          default:            ;
        endcase
      end
      if (out_valid_q && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            u_q         <= fds_pkg::sat32(70'(u_sum));
            dt_q        <= sample_time_i - last_time_q;
            last_time_q <= sample_time_i;
            t1_q        <= t1_c;
          end
        end
        ST_DECIDE: dt20_q <= dt20_c;
        ST_SNAP_W: begin
          lag_q  <= fds_pkg::sat32(prod_q >>> 16);
          rate_q <= '0;
        end
        ST_SG_W: begin
          if (div_load) avg_q <= fds_pkg::sat32(prod_q >>> 17);
          if (div_done_q) w_q <= div_quo_q[34:0];
        end
        ST_SG_LAG: begin
          lag_q <= lag_new;
          d_q   <= d_sg;
        end
        ST_SS_N: begin
          if (div_done_q) begin
            n_q <= (div_quo_q >= 64'(MAX_SUBSTEPS)) ? NW'(MAX_SUBSTEPS)
                                                     : div_quo_q[NW-1:0];
          end
        end
        ST_SS_Q: begin
          if (div_done_q) begin
            q0_q <= div_quo_q[31:0];
            f_q  <= div_quo_q[31:0];
            r0_q <= div_rem_q;
            r_q  <= div_rem_q;
            k_q  <= NW'(1);
          end
        end
        ST_SS_INIT: begin
          nt1_q  <= prod_q[32:0];
          pin_q  <= ls_q;
          ival_q <= lag_q;
          diff_q <= 33'(u_q) - 33'(ls_q);
        end
        ST_K_INKW: begin
          ink_q <= fds_pkg::sat32(70'(ls_q) + 70'(fds_pkg::sat33(prod_q >>> 32)));
        end
        ST_K_Y: begin
          y_q <= 31'((33'(fds_pkg::sat32(prod_q >>> 17)) - 33'(ival_q)) >>> 2);
        end
        ST_K_UPD: begin
          ival_q <= fds_pkg::sat32(70'(ival_q) + 70'(qc));
          pin_q  <= ink_q;
          k_q    <= k_q + NW'(1);
          // ramp fraction advances by t1/dt20 with carried remainder
          if (r_sum >= 38'(dt20_q)) begin
            r_q <= 37'(r_sum - 38'(dt20_q));
            f_q <= f_q + q0_q + 32'd1;
          end else begin
            r_q <= r_sum[36:0];
            f_q <= f_q + q0_q;
          end
        end
        ST_FN_D: d_q <= 33'(fds_pkg::sat32(prod_q >>> 17)) - 33'(ival_q);
        ST_FN_W: if (div_done_q) w_q <= div_quo_q[34:0];
        ST_FN_LAG: begin
          lag_q <= fds_pkg::sat32(70'(ival_q) + 70'(fds_pkg::sat36(prod_q >>> 32)));
        end
        ST_RATE: if (div_done_q) rate_q <= fds_pkg::sat32(70'(rq_s));
        ST_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            deriv_q     <= rate_q;
            ls_q        <= u_q;
          end
        end
        default: ;
      endcase
    end
  end

  `FDS_ASSERT_NEVER(a_div_run_done, div_run_q && div_done_q)
  `FDS_ASSERT(a_k_in_range, (state_q == ST_K_UPD) |-> (k_q != '0) && (k_q <= n_q))
  `FDS_ASSERT(a_out_from_seq, $rose(out_valid_q) |-> $past(state_q == ST_OUT))
  `FDS_ASSERT(a_div_only_in_div_state, div_run_q |-> div_state)

endmodule
